>>> rtl/baali_pkg.sv
`default_nettype none

package baali_pkg;

    localparam int SEQ_SPACE = 4096;
    localparam int LINK_W    = 4;
    localparam int SEQ_W     = $clog2(SEQ_SPACE);
    localparam int BITMAP_W  = 64;
    localparam int LEN_W     = 13;
    localparam int MISS_W    = 7;
    localparam int GROUP_W   = 8;
    localparam int GCNT_W    = 4;

    typedef struct packed {
        logic [LEN_W-1:0]  ampdu_length;
        logic [MISS_W-1:0] newly_missing;
        logic              loss_after_clean;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/baali_ack_if.sv
`default_nettype none

interface baali_ack_if
    import baali_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [LINK_W-1:0]   link_index;
    logic [SEQ_W-1:0]    start_seq;
    logic [BITMAP_W-1:0] ack_bitmap;
    logic                answers_request;

    modport source (
        output valid, link_index, start_seq, ack_bitmap, answers_request,
        input  ready
    );

    modport sink (
        input  valid, link_index, start_seq, ack_bitmap, answers_request,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/baali_res_if.sv
`default_nettype none

interface baali_res_if
    import baali_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  ampdu_length;
    logic [MISS_W-1:0] newly_missing;
    logic              loss_after_clean;

    modport source (
        output valid, ampdu_length, newly_missing, loss_after_clean,
        input  ready
    );

    modport sink (
        input  valid, ampdu_length, newly_missing, loss_after_clean,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/block_ack_ampdu_length_inference.sv
`default_nettype none
// An accepted block ack passes the read, align, partial-count and result registers.
// Throughput: one block ack per cycle unless the output stalls; the link store is read and written
// once per ack through a read-first port, so consecutive acks of one link need no stall.
// Reset: after i_rst_n the link-seen store is cleared, one entry per cycle,
// through all LINKS entries in turn; no ack is accepted during that pass.

module block_ack_ampdu_length_inference
    import baali_pkg::*;
#(
    parameter int LINKS       = 16,
    parameter int BITMAP_BITS = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    baali_ack_if.sink  i_ack,
    baali_res_if.source o_res
);
    localparam int AW  = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int LXW = AW + LINK_W;
    localparam int DW  = SEQ_W + BITMAP_BITS;

    logic                   r_clr_busy;
    logic [AW-1:0]          r_clr_addr;
    logic                   r_r_valid;
    logic [SEQ_W-1:0]       r_r_seq;
    logic [BITMAP_BITS-1:0] r_r_bm;

    logic [LXW-1:0]         link_ext;
    logic                   link_ok;
    logic [AW-1:0]          link_addr;
    logic                   accept;
    logic                   store;
    logic [AW-1:0]          seen_addr;
    logic                   seen_we;
    logic                   seen_rd;
    logic [DW-1:0]          data_rd;
    logic                   align_ready;
    logic                   stage_ready;
    logic                   s_valid;
    logic                   s_ready;
    logic [BITMAP_BITS-1:0] s_old_only;
    logic [BITMAP_BITS-1:0] s_cur_only;
    logic [SEQ_W-1:0]       s_len_base;
    logic                   s_loss;
    t_result                res;

    assign link_ext  = LXW'(i_ack.link_index);
    assign link_ok   = link_ext < LXW'(LINKS);
    assign link_addr = link_ext[AW-1:0];

    assign stage_ready = !r_r_valid || align_ready;
    assign i_ack.ready = !r_clr_busy && stage_ready;
    assign accept      = i_ack.valid && i_ack.ready;
    assign store       = accept && link_ok;

    assign seen_addr = r_clr_busy ? r_clr_addr : link_addr;
    assign seen_we   = r_clr_busy || store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(LINKS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    baali_ram #(
        .WIDTH (1),
        .DEPTH (LINKS)
    ) u_seen_ram (
        .i_clk   (i_clk),
        .i_addr  (seen_addr),
        .i_re    (accept),
        .i_we    (seen_we),
        .i_wdata (!r_clr_busy),
        .o_rdata (seen_rd)
    );

    baali_ram #(
        .WIDTH (DW),
        .DEPTH (LINKS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_addr  (link_addr),
        .i_re    (accept),
        .i_we    (store),
        .i_wdata ({i_ack.start_seq, i_ack.ack_bitmap[BITMAP_BITS-1:0]}),
        .o_rdata (data_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (stage_ready) begin
            r_r_valid <= store && !i_ack.answers_request;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_r_seq <= i_ack.start_seq;
            r_r_bm  <= i_ack.ack_bitmap[BITMAP_BITS-1:0];
        end
    end

    baali_align #(
        .BITMAP_BITS (BITMAP_BITS)
    ) u_align (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_r_valid),
        .i_seen     (seen_rd),
        .o_ready    (align_ready),
        .i_seq      (r_r_seq),
        .i_pseq     (data_rd[DW-1:BITMAP_BITS]),
        .i_bm       (r_r_bm),
        .i_pbm      (data_rd[BITMAP_BITS-1:0]),
        .o_valid    (s_valid),
        .i_ready    (s_ready),
        .o_old_only (s_old_only),
        .o_cur_only (s_cur_only),
        .o_len_base (s_len_base),
        .o_loss     (s_loss)
    );

    baali_count #(
        .BITMAP_BITS (BITMAP_BITS)
    ) u_count (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_valid),
        .o_ready    (s_ready),
        .i_old_only (s_old_only),
        .i_cur_only (s_cur_only),
        .i_len_base (s_len_base),
        .i_loss     (s_loss),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_res      (res)
    );

    assign o_res.ampdu_length     = res.ampdu_length;
    assign o_res.newly_missing    = res.newly_missing;
    assign o_res.loss_after_clean = res.loss_after_clean;
endmodule

`default_nettype wire

>>> rtl/baali_ram.sv
`default_nettype none

module baali_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic                                  i_re,
    input  wire logic                                  i_we,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

>>> rtl/baali_align.sv
`default_nettype none

module baali_align
    import baali_pkg::*;
#(
    parameter int BITMAP_BITS = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic                   i_seen,
    output logic                        o_ready,
    input  wire logic [SEQ_W-1:0]       i_seq,
    input  wire logic [SEQ_W-1:0]       i_pseq,
    input  wire logic [BITMAP_BITS-1:0] i_bm,
    input  wire logic [BITMAP_BITS-1:0] i_pbm,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [BITMAP_BITS-1:0]      o_old_only,
    output logic [BITMAP_BITS-1:0]      o_cur_only,
    output logic [SEQ_W-1:0]            o_len_base,
    output logic                        o_loss
);
    localparam int SW = $clog2(BITMAP_BITS);

    logic                   r_valid;
    logic [BITMAP_BITS-1:0] r_old_only;
    logic [BITMAP_BITS-1:0] r_cur_only;
    logic [SEQ_W-1:0]       r_len_base;
    logic                   r_loss;

    logic [BITMAP_BITS-1:0] cur_miss;
    logic [BITMAP_BITS-1:0] old_miss;
    logic [SEQ_W:0]         seq_diff;
    logic [SEQ_W:0]         neg_diff;
    logic                   diff_neg;
    logic [SEQ_W-1:0]       mag;
    logic                   in_rng;
    logic [SW-1:0]          sh;
    logic [BITMAP_BITS-1:0] cur_al;
    logic [BITMAP_BITS-1:0] old_al;
    logic                   advance;

    assign cur_miss = ~i_bm;
    assign old_miss = ~i_pbm;
    assign seq_diff = {1'b0, i_seq} - {1'b0, i_pseq};
    assign neg_diff = -seq_diff;
    assign diff_neg = seq_diff[SEQ_W];
    assign mag      = diff_neg ? neg_diff[SEQ_W-1:0] : seq_diff[SEQ_W-1:0];
    assign in_rng   = mag < SEQ_W'(BITMAP_BITS);
    assign sh       = mag[SW-1:0];

    always_comb begin
        cur_al = '0;
        old_al = '0;
        if (in_rng) begin
            if (diff_neg) begin
                cur_al = cur_miss >> sh;
                old_al = old_miss << sh;
            end else begin
                cur_al = cur_miss << sh;
                old_al = old_miss >> sh;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign advance = o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid && i_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_old_only <= old_miss & ~cur_al;
            r_cur_only <= cur_miss & ~old_al;
            r_len_base <= seq_diff[SEQ_W-1:0];
            r_loss     <= (|cur_miss) && !(|old_miss);
        end
    end

    assign o_valid    = r_valid;
    assign o_old_only = r_old_only;
    assign o_cur_only = r_cur_only;
    assign o_len_base = r_len_base;
    assign o_loss     = r_loss;
endmodule

`default_nettype wire

>>> rtl/baali_count.sv
`default_nettype none

module baali_count
    import baali_pkg::*;
#(
    parameter int BITMAP_BITS = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [BITMAP_BITS-1:0] i_old_only,
    input  wire logic [BITMAP_BITS-1:0] i_cur_only,
    input  wire logic [SEQ_W-1:0]       i_len_base,
    input  wire logic                   i_loss,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output t_result                     o_res
);
    localparam int NG    = (BITMAP_BITS + GROUP_W - 1) / GROUP_W;
    localparam int PAD_W = NG * GROUP_W;

    logic              r_p_valid;
    logic [GCNT_W-1:0] r_p_old [NG];
    logic [GCNT_W-1:0] r_p_cur [NG];
    logic [SEQ_W-1:0]  r_p_len;
    logic              r_p_loss;
    logic              r_o_valid;
    t_result           r_res;

    logic [PAD_W-1:0]  old_pad;
    logic [PAD_W-1:0]  cur_pad;
    logic [GCNT_W-1:0] n_p_old [NG];
    logic [GCNT_W-1:0] n_p_cur [NG];
    logic [MISS_W-1:0] old_sum;
    logic [MISS_W-1:0] cur_sum;
    logic              p_ready;
    logic              o_adv;

    assign old_pad = PAD_W'(i_old_only);
    assign cur_pad = PAD_W'(i_cur_only);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_p_old[g] = '0;
            n_p_cur[g] = '0;
            for (int b = 0; b < GROUP_W; b++) begin
                n_p_old[g] = n_p_old[g] + GCNT_W'(old_pad[g*GROUP_W+b]);
                n_p_cur[g] = n_p_cur[g] + GCNT_W'(cur_pad[g*GROUP_W+b]);
            end
        end
    end

    always_comb begin
        old_sum = '0;
        cur_sum = '0;
        for (int g = 0; g < NG; g++) begin
            old_sum = old_sum + MISS_W'(r_p_old[g]);
            cur_sum = cur_sum + MISS_W'(r_p_cur[g]);
        end
    end

    assign o_adv   = !r_o_valid || i_ready;
    assign p_ready = !r_p_valid || o_adv;
    assign o_ready = p_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (p_ready) begin
                r_p_valid <= i_valid;
            end
            if (o_adv) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_ready) begin
            r_p_old  <= n_p_old;
            r_p_cur  <= n_p_cur;
            r_p_len  <= i_len_base;
            r_p_loss <= i_loss;
        end
        if (o_adv) begin
            r_res.ampdu_length     <= LEN_W'(r_p_len) + LEN_W'(old_sum);
            r_res.newly_missing    <= cur_sum;
            r_res.loss_after_clean <= r_p_loss;
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_res;
endmodule

`default_nettype wire
